/* sv/tas_pkg.sv */
// Shared types and constants for the tamper alarm supervisor.
// No dependencies; compile first.
`default_nettype none
package tas_pkg;

    localparam int TimerWidth = 16;
    localparam int CfgIndexWidth = 2;

    localparam logic [TimerWidth-1:0] TIMER_MAX = 16'hFFFF;

    localparam logic [TimerWidth-1:0] QUICK_LIMIT_RESET = 16'd10;
    localparam logic [TimerWidth-1:0] SLOW_LIMIT_RESET  = 16'd300;
    localparam logic [TimerWidth-1:0] BEEP_LIMIT_RESET  = 16'd300;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_QUICK_LIMIT = 2'd0,
        REG_SLOW_LIMIT  = 2'd1,
        REG_BEEP_LIMIT  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic open_level;
        logic tilt_level;
        logic check_enabled;
        logic supply_low;
    } tick_t;

    typedef struct packed {
        logic       reenable_request;
        logic       beep_request;
        logic       report_tilt;
        logic       report_open;
        logic       tamper_latched;
        logic       alarm_active;
        logic [1:0] error_count;
    } result_t;

    typedef struct packed {
        logic [CfgIndexWidth-1:0] index;
        logic [TimerWidth-1:0]    data;
    } cfg_write_t;

    typedef struct packed {
        logic [TimerWidth-1:0] quick_limit;
        logic [TimerWidth-1:0] slow_limit;
        logic [TimerWidth-1:0] beep_limit;
    } limits_t;

endpackage
`default_nettype wire

/* sv/tas_tick_if.sv */
// Input tick channel: valid/ready with one tick_t payload.
// Depends on tas_pkg.
`default_nettype none
interface tas_tick_if;
    logic           valid;
    logic           ready;
    tas_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tas_result_if.sv */
// Result channel: valid/ready with one result_t payload.
// Depends on tas_pkg.
`default_nettype none
interface tas_result_if;
    logic             valid;
    logic             ready;
    tas_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tas_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
// Depends on tas_pkg.
`default_nettype none
interface tas_cfg_if;
    logic                valid;
    logic                ready;
    tas_pkg::cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tas_cfg_regs.sv */
// Configuration register file: three 16-bit limits.
// Depends on tas_pkg and tas_cfg_if.
`default_nettype none
module tas_cfg_regs (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tas_cfg_if.sink         cfg,
    output tas_pkg::limits_t limits
);
    import tas_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;
    logic    write_en;

    assign cfg.ready = 1'b1;
    assign write_en  = cfg.valid && cfg.ready;

    always_comb
    begin
        limits_next = limits_reg;
        if (write_en)
        begin
            unique case (cfg.data.index)
                REG_QUICK_LIMIT: limits_next.quick_limit = cfg.data.data;
                REG_SLOW_LIMIT:  limits_next.slow_limit  = cfg.data.data;
                REG_BEEP_LIMIT:  limits_next.beep_limit  = cfg.data.data;
                default:         limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.quick_limit <= QUICK_LIMIT_RESET;
            limits_reg.slow_limit  <= SLOW_LIMIT_RESET;
            limits_reg.beep_limit  <= BEEP_LIMIT_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule
`default_nettype wire

/* sv/tas_core.sv */
// Supervisor state and per-tick update logic; result is combinational.
// Depends on tas_pkg.
`default_nettype none
module tas_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire tas_pkg::tick_t    tick,
    input  wire tas_pkg::limits_t  limits,
    output tas_pkg::result_t       result
);
    import tas_pkg::*;

    logic                  last_open_reg,  last_open_next;
    logic                  last_tilt_reg,  last_tilt_next;
    logic                  opened_reg,     opened_next;
    logic                  tilted_reg,     tilted_next;
    logic                  alarm_reg,      alarm_next;
    logic [TimerWidth-1:0] reenable_reg,   reenable_next;
    logic [TimerWidth-1:0] repeat_reg,     repeat_next;

    logic                  tamper_prev;
    logic                  tamper_now;
    logic [TimerWidth-1:0] limit_sel;
    logic                  fire;
    logic                  enabled_eff;
    logic [TimerWidth-1:0] repeat_inc;
    logic                  beep;
    logic                  rep_tilt;
    logic                  rep_open;

    // tamper_seen from the previous tick equals the OR of the sticky flags
    assign tamper_prev = opened_reg | tilted_reg;
    assign limit_sel   = tamper_prev ? limits.slow_limit : limits.quick_limit;
    assign fire        = !tick.check_enabled && (reenable_reg > limit_sel);
    assign enabled_eff = tick.check_enabled || fire;

    always_comb
    begin
        if (tick.check_enabled)
            reenable_next = '0;
        else if (reenable_reg != TIMER_MAX)
            reenable_next = reenable_reg + 1'b1;
        else
            reenable_next = reenable_reg;
    end

    assign last_open_next = tick.open_level;
    assign last_tilt_next = tick.tilt_level;
    assign opened_next    = opened_reg | (tick.open_level & ~last_open_reg);
    assign tilted_next    = tilted_reg | (tick.tilt_level & ~last_tilt_reg);
    assign tamper_now     = opened_next | tilted_next;
    assign repeat_inc     = repeat_reg + 1'b1;

    always_comb
    begin
        alarm_next  = alarm_reg;
        repeat_next = repeat_reg;
        beep        = 1'b0;
        rep_tilt    = 1'b0;
        rep_open    = 1'b0;
        if (enabled_eff)
        begin
            if (tamper_now)
            begin
                if (!alarm_reg)
                begin
                    alarm_next  = 1'b1;
                    repeat_next = '0;
                    beep        = 1'b1;
                    rep_tilt    = tilted_next;
                    rep_open    = opened_next;
                end
                else if (repeat_reg != TIMER_MAX)
                begin
                    if (repeat_inc > limits.beep_limit)
                    begin
                        repeat_next = '0;
                        beep        = 1'b1;
                    end
                    else
                    begin
                        repeat_next = repeat_inc;
                    end
                end
            end
            else
            begin
                alarm_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.reenable_request = fire;
        result.beep_request     = beep;
        result.report_tilt      = rep_tilt;
        result.report_open      = rep_open;
        result.tamper_latched   = tamper_now;
        result.alarm_active     = alarm_next;
        result.error_count      = {1'b0, tick.supply_low} + {1'b0, tamper_now};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_open_reg <= 1'b1;
            last_tilt_reg <= 1'b1;
            opened_reg    <= 1'b0;
            tilted_reg    <= 1'b0;
            alarm_reg     <= 1'b0;
            reenable_reg  <= '0;
            repeat_reg    <= '0;
        end
        else if (step)
        begin
            last_open_reg <= last_open_next;
            last_tilt_reg <= last_tilt_next;
            opened_reg    <= opened_next;
            tilted_reg    <= tilted_next;
            alarm_reg     <= alarm_next;
            reenable_reg  <= reenable_next;
            repeat_reg    <= repeat_next;
        end
    end

    // sticky flags never clear
    a_opened_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        opened_reg |=> opened_reg)
        else $error("opened flag cleared");

    a_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        step && tick.check_enabled |=> reenable_reg == '0)
        else $error("re-enable timer not cleared while enabled");

    a_report_needs_beep: assert property (@(posedge clk) disable iff (!rst_n)
        (result.report_tilt || result.report_open) |-> result.beep_request && !alarm_reg)
        else $error("report without a new alarm");

    a_beep_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        result.beep_request |-> result.alarm_active && result.tamper_latched)
        else $error("beep without active alarm");

endmodule
`default_nettype wire

/* sv/tamper_alarm_supervisor.sv */
// Tamper alarm supervisor top level: input register, core update, result register.
// Ticks pass the input register, then the core into the result register. Throughput:
// one tick per cycle unless the result stalls; an empty input register still takes
// a tick while the result waits. Reset (rst_n low, async): pipeline empty, limits
// 10/300/300, sensor history 1, flags, alarm and timers cleared. No clearing pass.
`default_nettype none
module tamper_alarm_supervisor (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tas_tick_if.sink     tick,
    tas_result_if.source result,
    tas_cfg_if.sink      cfg
);
    import tas_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    tick_t   tick_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t core_result;
    limits_t limits;
    logic    advance;
    logic    take;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign take = tick.valid && tick.ready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    tas_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    tas_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (tick_reg),
        .limits (limits),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            tick_reg <= tick.data;
        if (advance)
            result_reg <= core_result;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for tamper_alarm_supervisor: directed and random one-second ticks,
// with a scoreboard class that predicts each result and checks it field by field.
// Depends on tas_pkg, the tick/result/cfg interfaces and the supervisor RTL.
`default_nettype none
module tb;
    import tas_pkg::*;

    localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 2'd3;
    localparam int LONG_RUN = 24;

    class tamper_scoreboard;
        limits_t              limits;
        logic                 last_open;
        logic                 last_tilt;
        logic                 opened;
        logic                 tilted;
        logic                 tamper_seen;
        logic                 alarm;
        logic [TimerWidth-1:0] reenable_timer;
        logic [TimerWidth-1:0] repeat_timer;
        result_t              expected_q[$];
        int unsigned          mismatches;
        int unsigned          checked;
        int unsigned          requests;
        int unsigned          beeps;
        int unsigned          writes;

        function new();
            limits.quick_limit = QUICK_LIMIT_RESET;
            limits.slow_limit  = SLOW_LIMIT_RESET;
            limits.beep_limit  = BEEP_LIMIT_RESET;
            last_open      = 1'b1;
            last_tilt      = 1'b1;
            opened         = 1'b0;
            tilted         = 1'b0;
            tamper_seen    = 1'b0;
            alarm          = 1'b0;
            reenable_timer = '0;
            repeat_timer   = '0;
            mismatches     = 0;
            checked        = 0;
            requests       = 0;
            beeps          = 0;
            writes         = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_limit(logic [CfgIndexWidth-1:0] idx, logic [TimerWidth-1:0] val);
            writes++;
            case (idx)
                REG_QUICK_LIMIT: limits.quick_limit = val;
                REG_SLOW_LIMIT:  limits.slow_limit  = val;
                REG_BEEP_LIMIT:  limits.beep_limit  = val;
                default: ;
            endcase
        endfunction

        function void note_tick(tick_t t);
            logic                  enabled;
            logic                  fire;
            logic [TimerWidth-1:0] lim;
            result_t               r;
            r = '0;
            enabled = t.check_enabled;
            if (!enabled)
            begin
                lim  = tamper_seen ? limits.slow_limit : limits.quick_limit;
                fire = reenable_timer > lim;
                if (reenable_timer != TIMER_MAX)
                    reenable_timer++;
                if (fire)
                begin
                    r.reenable_request = 1'b1;
                    enabled = 1'b1;
                end
            end
            else
                reenable_timer = '0;

            if (t.open_level != last_open)
            begin
                last_open = t.open_level;
                if (t.open_level)
                    opened = 1'b1;
            end
            if (t.tilt_level != last_tilt)
            begin
                last_tilt = t.tilt_level;
                if (t.tilt_level)
                    tilted = 1'b1;
            end
            tamper_seen = opened | tilted;

            if (enabled)
            begin
                if (tamper_seen)
                begin
                    if (!alarm)
                    begin
                        alarm          = 1'b1;
                        repeat_timer   = '0;
                        r.beep_request = 1'b1;
                        r.report_tilt  = tilted;
                        r.report_open  = opened;
                    end
                    else if (repeat_timer != TIMER_MAX)
                    begin
                        repeat_timer++;
                        if (repeat_timer > limits.beep_limit)
                        begin
                            repeat_timer   = '0;
                            r.beep_request = 1'b1;
                        end
                    end
                end
                else
                    alarm = 1'b0;
            end

            r.tamper_latched = tamper_seen;
            r.alarm_active   = alarm;
            r.error_count    = {1'b0, t.supply_low} + {1'b0, tamper_seen};
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR @%0t result %0d: %s", $time, checked, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [1:0] got, logic [1:0] exp);
            if (got !== exp)
                report($sformatf("%s got %0d expected %0d", name, got, exp));
        endtask

        task check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                report("result with no pending tick");
                return;
            end
            exp = expected_q.pop_front();
            check_field("reenable_request", 2'(got.reenable_request),
                        2'(exp.reenable_request));
            check_field("beep_request", 2'(got.beep_request), 2'(exp.beep_request));
            check_field("report_tilt", 2'(got.report_tilt), 2'(exp.report_tilt));
            check_field("report_open", 2'(got.report_open), 2'(exp.report_open));
            check_field("tamper_latched", 2'(got.tamper_latched), 2'(exp.tamper_latched));
            check_field("alarm_active", 2'(got.alarm_active), 2'(exp.alarm_active));
            check_field("error_count", got.error_count, exp.error_count);
            checked++;
            if (exp.reenable_request)
                requests++;
            if (exp.beep_request)
                beeps++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    bit   cur_open;
    bit   cur_tilt;
    bit   cur_en;

    tamper_scoreboard sb;

    tas_tick_if   tick_ch();
    tas_result_if result_ch();
    tas_cfg_if    cfg_ch();

    tamper_alarm_supervisor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        result_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 18) : 1'b1;

    // one transaction per channel per edge at most
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && sb != null)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_limit(cfg_ch.data.index, cfg_ch.data.data);
            if (tick_ch.valid && tick_ch.ready)
                sb.note_tick(tick_ch.data);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.data);
        end
    end

    task automatic send_tick(tick_t t);
        while (idle_on && $urandom_range(0, 99) < 18)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_levels(bit o, bit t, bit e, bit lp);
        tick_t item;
        item.open_level    = o;
        item.tilt_level    = t;
        item.check_enabled = e;
        item.supply_low    = lp;
        cur_open = o;
        cur_tilt = t;
        cur_en   = e;
        send_tick(item);
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(logic [CfgIndexWidth-1:0] idx, logic [TimerWidth-1:0] val);
        cfg_write_t w;
        w.index = idx;
        w.data  = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // rising sensor edges only where a tamper may be latched
    task automatic run_random(int n, bit allow_rise);
        bit o;
        bit t;
        bit e;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 63) == 0)
                drain();
            o = cur_open;
            t = cur_tilt;
            e = cur_en;
            if ($urandom_range(0, 11) == 0)
                e = ~e;
            if ($urandom_range(0, 7) == 0)
                o = allow_rise ? ~o : 1'b0;
            if ($urandom_range(0, 7) == 0)
                t = allow_rise ? ~t : 1'b0;
            if (allow_rise && $urandom_range(0, 9) == 0)
            begin
                o = 1'($urandom_range(0, 1));
                t = 1'($urandom_range(0, 1));
                e = 1'($urandom_range(0, 1));
            end
            send_levels(o, t, e, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_held(int n, bit e);
        repeat (n)
            send_levels(cur_open, cur_tilt, e, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        sb = new();
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        tick_ch.valid   = 1'b0;
        tick_ch.data    = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits, no tamper: quick re-enable fires on the 12th disabled tick
        send_levels(1, 1, 1, 0);
        for (int i = 0; i < 13; i++)
            send_levels(1, 1, 0, i[0]);
        send_levels(0, 0, 1, 1);
        send_levels(0, 1, 1, 0);

        settle();
        set_reg(REG_QUICK_LIMIT, 16'd0);
        run_random(150, 1'b0);

        // near-top quick limit: held disabled ticks stay quiet, no idling
        settle();
        set_reg(REG_QUICK_LIMIT, 16'hFFFE);
        idle_on = 1'b0;
        run_held(LONG_RUN, 1'b0);
        idle_on = 1'b1;

        settle();
        set_reg(REG_QUICK_LIMIT, 16'hFFFF);
        set_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        run_random(120, 1'b0);

        // latch open while disabled; tilt and the alarm are latched already, so no report
        settle();
        set_reg(REG_QUICK_LIMIT, 16'd3);
        set_reg(REG_SLOW_LIMIT, 16'd1);
        set_reg(REG_BEEP_LIMIT, 16'd2);
        send_levels(0, 0, 1, 0);
        send_levels(1, 0, 0, 1);
        send_levels(1, 1, 0, 0);
        send_levels(1, 1, 1, 1);
        send_levels(1, 1, 1, 0);
        send_levels(1, 1, 1, 1);
        send_levels(1, 1, 1, 0);
        send_levels(0, 0, 1, 1);
        send_levels(0, 0, 0, 0);
        send_levels(0, 0, 0, 1);
        send_levels(0, 0, 0, 1);

        settle();
        set_reg(REG_SLOW_LIMIT, 16'd0);
        set_reg(REG_BEEP_LIMIT, 16'd0);
        run_random(150, 1'b1);

        settle();
        set_reg(REG_SLOW_LIMIT, 16'd7);
        set_reg(REG_BEEP_LIMIT, 16'd3);
        run_random(150, 1'b1);

        settle();
        set_reg(REG_SLOW_LIMIT, 16'hFFFF);
        set_reg(REG_BEEP_LIMIT, 16'd1);
        idle_on = 1'b0;
        run_random(150, 1'b1);
        idle_on = 1'b1;

        settle();
        set_reg(REG_SLOW_LIMIT, 16'd20);
        set_reg(REG_BEEP_LIMIT, 16'd10);
        run_random(150, 1'b1);

        // repeat limits at the top: no repeated beep during a short hold
        settle();
        set_reg(REG_BEEP_LIMIT, 16'hFFFE);
        idle_on = 1'b0;
        run_held(LONG_RUN, 1'b1);
        settle();
        set_reg(REG_BEEP_LIMIT, 16'hFFFF);
        run_held(LONG_RUN, 1'b1);
        idle_on = 1'b1;

        settle();
        set_reg(REG_SLOW_LIMIT, 16'd2);
        set_reg(REG_BEEP_LIMIT, 16'd5);
        set_reg(REG_UNUSED, 16'hFFFF);
        run_random(150, 1'b1);

        settle();
        $display("Checked %0d ticks across %0d register writes, quick/slow/beep limits",
                 sb.checked, sb.writes);
        $display("from 0 to 0xFFFF; saw %0d re-enable requests and %0d beeps",
                 sb.requests, sb.beeps);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/tas_pkg.sv
sv/tas_tick_if.sv
sv/tas_result_if.sv
sv/tas_cfg_if.sv
sv/tas_cfg_regs.sv
sv/tas_core.sv
sv/tamper_alarm_supervisor.sv
verif/tb.sv
